/* hdl/slpm_pkg.sv */
// slpm_pkg: shared types and constants of the sliding latency percentile monitor
// used by slpm_select and sliding_latency_percentile_monitor_unit
// no dependencies
package slpm_pkg;

	// register map, byte address is 4 * index
	localparam int REG_ADDR_BITS = 5;
	localparam logic [2:0] REG_WINDOW_SIZE     = 3'd0;
	localparam logic [2:0] REG_ROUTE_FRACTION  = 3'd1;
	localparam logic [2:0] REG_SAMPLES_NEEDED  = 3'd2;
	localparam logic [2:0] REG_FAST_BELOW      = 3'd3;
	localparam logic [2:0] REG_DECLARED_BUDGET = 3'd4;
	localparam logic [2:0] REG_DECLARED_FAST   = 3'd5;
	localparam logic [2:0] REG_DEFAULT_BUDGET  = 3'd6;
	localparam logic [2:0] REG_BOOT_SLACK      = 3'd7;

	// register reset values
	localparam logic [6:0]  RST_WINDOW_SIZE     = 7'd64;
	localparam logic [16:0] RST_ROUTE_FRACTION  = 17'd58982;
	localparam logic [6:0]  RST_SAMPLES_NEEDED  = 7'd8;
	localparam logic [15:0] RST_FAST_BELOW      = 16'd1000;
	localparam logic [15:0] RST_DECLARED_BUDGET = 16'd0;
	localparam logic        RST_DECLARED_FAST   = 1'b0;
	localparam logic [15:0] RST_DEFAULT_BUDGET  = 16'd2000;
	localparam logic [15:0] RST_BOOT_SLACK      = 16'd1000;

	// control from the sequencer to the selection engine
	typedef struct packed {
		logic start;
		logic wr_en;
	} slpm_ctl_t;

	// status back from the selection engine
	typedef struct packed {
		logic busy;
		logic done;
	} slpm_sts_t;

endpackage

/* hdl/slpm_select.sv */
// slpm_select: latency ring memory and bitwise radix rank selection engine
// finds two order statistics of the window in one pass per latency bit
// depends on slpm_pkg
module slpm_select #(
	parameter int WINDOW_DEPTH = 64,
	parameter int LATENCY_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  slpm_pkg::slpm_ctl_t               ctl,
	output slpm_pkg::slpm_sts_t               sts,
	input  logic [$clog2(WINDOW_DEPTH)-1:0]   wr_addr,
	input  logic [LATENCY_BITS-1:0]           wr_data,
	input  logic [$clog2(WINDOW_DEPTH)-1:0]   start_slot,
	input  logic [$clog2(WINDOW_DEPTH+1)-1:0] count,
	input  logic [$clog2(WINDOW_DEPTH+1)-1:0] rank_a,
	input  logic [$clog2(WINDOW_DEPTH+1)-1:0] rank_b,
	output logic [LATENCY_BITS-1:0]           value_a,
	output logic [LATENCY_BITS-1:0]           value_b
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int NW = $clog2(WINDOW_DEPTH + 1);

	localparam logic [1:0] EN_IDLE  = 2'd0;
	localparam logic [1:0] EN_RUN   = 2'd1;
	localparam logic [1:0] EN_DRAIN = 2'd2;
	localparam logic [1:0] EN_UPD   = 2'd3;

	logic [LATENCY_BITS-1:0] ring [WINDOW_DEPTH];

	logic [1:0]              st_q;
	logic [AW-1:0]           addr_q;
	logic [AW-1:0]           first_q;
	logic [NW-1:0]           j_q;
	logic [NW-1:0]           n_q;
	logic [NW-1:0]           ka_q, kb_q;
	logic [NW-1:0]           ca_q, cb_q;
	logic [LATENCY_BITS-1:0] pa_q, pb_q;
	logic [LATENCY_BITS-1:0] hi_q, bsel_q;
	logic [LATENCY_BITS-1:0] rdata_s1;
	logic                    vld_s1;
	logic                    issue;
	logic                    hit_a, hit_b;
	logic [AW-1:0]           addr_nx;

	assign issue   = (st_q == EN_RUN);
	assign addr_nx = (addr_q == AW'(WINDOW_DEPTH - 1)) ? '0 : addr_q + AW'(1);

	// element lies under the current prefix and has a zero at the bit under test
	assign hit_a = (((rdata_s1 ^ pa_q) & hi_q) == '0) && ((rdata_s1 & bsel_q) == '0);
	assign hit_b = (((rdata_s1 ^ pb_q) & hi_q) == '0) && ((rdata_s1 & bsel_q) == '0);

	// ring memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			ring[wr_addr] <= wr_data;
		end
		if (issue) begin
			rdata_s1 <= ring[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= EN_IDLE;
			vld_s1  <= 1'b0;
			addr_q  <= '0;
			first_q <= '0;
			j_q     <= '0;
			n_q     <= '0;
			ka_q    <= '0;
			kb_q    <= '0;
			ca_q    <= '0;
			cb_q    <= '0;
			pa_q    <= '0;
			pb_q    <= '0;
			hi_q    <= '0;
			bsel_q  <= '0;
		end else begin
			vld_s1 <= issue;
			if (vld_s1) begin
				ca_q <= ca_q + NW'(hit_a);
				cb_q <= cb_q + NW'(hit_b);
			end
			case (st_q)
				EN_IDLE: begin
					if (ctl.start) begin
						st_q    <= EN_RUN;
						addr_q  <= start_slot;
						first_q <= start_slot;
						j_q     <= '0;
						n_q     <= count;
						ka_q    <= rank_a;
						kb_q    <= rank_b;
						ca_q    <= '0;
						cb_q    <= '0;
						pa_q    <= '0;
						pb_q    <= '0;
						hi_q    <= '0;
						bsel_q  <= {1'b1, {(LATENCY_BITS-1){1'b0}}};
					end
				end
				EN_RUN: begin
					addr_q <= addr_nx;
					j_q    <= j_q + NW'(1);
					if (j_q == n_q - NW'(1)) begin
						st_q <= EN_DRAIN;
					end
				end
				EN_DRAIN: begin
					st_q <= EN_UPD;
				end
				EN_UPD: begin
					// pick the bit for each rank, then narrow the prefix
					if (ka_q >= ca_q) begin
						pa_q <= pa_q | bsel_q;
						ka_q <= ka_q - ca_q;
					end
					if (kb_q >= cb_q) begin
						pb_q <= pb_q | bsel_q;
						kb_q <= kb_q - cb_q;
					end
					ca_q   <= '0;
					cb_q   <= '0;
					j_q    <= '0;
					addr_q <= first_q;
					hi_q   <= hi_q | bsel_q;
					bsel_q <= bsel_q >> 1;
					st_q   <= bsel_q[0] ? EN_IDLE : EN_RUN;
				end
				default: begin
					st_q <= EN_IDLE;
				end
			endcase
		end
	end

	assign sts.busy = (st_q != EN_IDLE);
	assign sts.done = (st_q == EN_UPD) && bsel_q[0];
	assign value_a  = pa_q;
	assign value_b  = pb_q;

endmodule

/* hdl/sliding_latency_percentile_monitor_unit.sv */
// sliding_latency_percentile_monitor_unit: top level of the latency percentile monitor
// apb register file, stream handshakes, item sequencer and result formatting
// depends on slpm_pkg and slpm_select
//
// Keeps the most recent latency samples (up to window_size, at most WINDOW_DEPTH) in a
// ring and answers each input transaction with one result transaction: the latency at
// the requested percentile, the measured speed class, the deadline and the sample
// count. A mode 0 transaction records its latency first, a mode 1 transaction only
// queries. Percentiles are found by a bitwise rank search over the ring memory: one
// pass over the n held samples per latency bit, both the query rank and the routing
// rank resolved in the same pass, so the time an item takes grows with n and is set
// by the single ring read port; an empty window answers without a rank search. The
// next transaction is taken while a finished result still waits on m_axis_tready.
// The ring needs no clearing after reset: only written entries are ever read.
module sliding_latency_percentile_monitor_unit #(
	parameter int WINDOW_DEPTH = 64,
	parameter int LATENCY_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// apb configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [slpm_pkg::REG_ADDR_BITS-1:0] paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// input stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [39:0]                        s_axis_tdata, // latency_ms[15:0], query_fraction[32:16]
	input  logic                               s_axis_tuser, // mode
	// result stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [47:0]                        m_axis_tdata  // query_latency_ms[15:0], measured_fast[16],
	                                                         // deadline_ms[33:17], sample_count[40:34]
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int NW = $clog2(WINDOW_DEPTH + 1);
	localparam int CW = (NW > 7) ? NW : 7;
	localparam int VW = (LATENCY_BITS > 16) ? LATENCY_BITS : 16;
	localparam int PW = NW + 17;
	localparam logic [LATENCY_BITS-1:0] LAT_MAX = '1;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_REC  = 3'd1;
	localparam logic [2:0] ST_IDXQ = 3'd2;
	localparam logic [2:0] ST_IDXR = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	// configuration registers
	logic [6:0]  win_q;
	logic [16:0] route_q;
	logic [6:0]  need_q;
	logic [15:0] fastb_q;
	logic [15:0] decl_q;
	logic        declf_q;
	logic [15:0] defb_q;
	logic [15:0] slack_q;

	// item and window state
	logic [2:0]    state_q;
	logic          mode_q;
	logic [15:0]   lat_q;
	logic [16:0]   qf_q;
	logic [AW-1:0] head_q;
	logic [NW-1:0] held_q;
	logic [NW-1:0] idxq_q;

	// result register
	logic        m_valid_q;
	logic [15:0] oq_q;
	logic        ofast_q;
	logic [16:0] odl_q;
	logic [6:0]  ocnt_q;

	logic                    cfg_wr;
	logic                    in_acc;
	logic                    out_load;
	slpm_pkg::slpm_ctl_t     eng_ctl;
	slpm_pkg::slpm_sts_t     eng_sts;
	logic [LATENCY_BITS-1:0] val_q, val_r;

	// ---------------------------------------------------------------- apb
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= slpm_pkg::RST_WINDOW_SIZE;
			route_q <= slpm_pkg::RST_ROUTE_FRACTION;
			need_q  <= slpm_pkg::RST_SAMPLES_NEEDED;
			fastb_q <= slpm_pkg::RST_FAST_BELOW;
			decl_q  <= slpm_pkg::RST_DECLARED_BUDGET;
			declf_q <= slpm_pkg::RST_DECLARED_FAST;
			defb_q  <= slpm_pkg::RST_DEFAULT_BUDGET;
			slack_q <= slpm_pkg::RST_BOOT_SLACK;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				slpm_pkg::REG_WINDOW_SIZE:     win_q   <= pwdata[6:0];
				slpm_pkg::REG_ROUTE_FRACTION:  route_q <= pwdata[16:0];
				slpm_pkg::REG_SAMPLES_NEEDED:  need_q  <= pwdata[6:0];
				slpm_pkg::REG_FAST_BELOW:      fastb_q <= pwdata[15:0];
				slpm_pkg::REG_DECLARED_BUDGET: decl_q  <= pwdata[15:0];
				slpm_pkg::REG_DECLARED_FAST:   declf_q <= pwdata[0];
				slpm_pkg::REG_DEFAULT_BUDGET:  defb_q  <= pwdata[15:0];
				slpm_pkg::REG_BOOT_SLACK:      slack_q <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			slpm_pkg::REG_WINDOW_SIZE:     prdata = 32'(win_q);
			slpm_pkg::REG_ROUTE_FRACTION:  prdata = 32'(route_q);
			slpm_pkg::REG_SAMPLES_NEEDED:  prdata = 32'(need_q);
			slpm_pkg::REG_FAST_BELOW:      prdata = 32'(fastb_q);
			slpm_pkg::REG_DECLARED_BUDGET: prdata = 32'(decl_q);
			slpm_pkg::REG_DECLARED_FAST:   prdata = 32'(declf_q);
			slpm_pkg::REG_DEFAULT_BUDGET:  prdata = 32'(defb_q);
			slpm_pkg::REG_BOOT_SLACK:      prdata = 32'(slack_q);
			default:                       prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- record path
	logic [VW-1:0]           lat_ext;
	logic [LATENCY_BITS-1:0] lat_sat;
	logic [CW-1:0]           win_ext, keep, held_ext, held_inc, held_new;

	// latencies above the storage range saturate
	assign lat_ext = VW'(lat_q);
	assign lat_sat = (lat_ext > VW'(LAT_MAX)) ? LAT_MAX : lat_ext[LATENCY_BITS-1:0];

	// window size register values above the ring depth act as the depth
	assign win_ext  = CW'(win_q);
	assign keep     = (win_ext > CW'(WINDOW_DEPTH)) ? CW'(WINDOW_DEPTH) : win_ext;
	assign held_ext = CW'(held_q);
	assign held_inc = (held_ext == CW'(WINDOW_DEPTH)) ? held_ext : held_ext + CW'(1);
	// shrinking the window trims old samples only here, on the next record
	assign held_new = (held_inc > keep) ? keep : held_inc;

	// ---------------------------------------------------------------- rank index
	logic [16:0]   frac_sel;
	logic [PW-1:0] prod;
	logic [NW:0]   idx_raw;
	logic [NW-1:0] idx_c;

	// one multiplier shared by the query rank and the routing rank
	assign frac_sel = (state_q == ST_IDXQ) ? qf_q : route_q;
	assign prod     = PW'(held_q) * PW'(frac_sel);
	assign idx_raw  = prod[PW-1:16];
	// fractions at or above one clamp to the largest sample
	assign idx_c    = (idx_raw >= (NW+1)'(held_q)) ? held_q - NW'(1) : idx_raw[NW-1:0];

	// oldest held sample sits n slots behind the head
	logic [NW:0]   head_ext, n_ext, start_ext;
	logic [AW-1:0] start_slot;

	assign head_ext   = (NW+1)'(head_q);
	assign n_ext      = (NW+1)'(held_q);
	assign start_ext  = (head_ext >= n_ext) ? head_ext - n_ext
	                                        : head_ext + (NW+1)'(WINDOW_DEPTH) - n_ext;
	assign start_slot = start_ext[AW-1:0];

	// ---------------------------------------------------------------- selection engine
	assign eng_ctl.start = (state_q == ST_IDXR);
	assign eng_ctl.wr_en = (state_q == ST_REC);

	slpm_select #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.LATENCY_BITS (LATENCY_BITS)
	) u_select (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (eng_ctl),
		.sts        (eng_sts),
		.wr_addr    (head_q),
		.wr_data    (lat_sat),
		.start_slot (start_slot),
		.count      (held_q),
		.rank_a     (idxq_q),
		.rank_b     (idx_c),
		.value_a    (val_q),
		.value_b    (val_r)
	);

	// ---------------------------------------------------------------- result formatting
	logic [VW-1:0] vq_ext, vr_ext;
	logic [15:0]   budget, query_v, route_v;
	logic [16:0]   route_dl, deadline_v;
	logic          boot, fast_v;

	assign vq_ext  = VW'(val_q);
	assign vr_ext  = VW'(val_r);
	assign budget  = (decl_q != '0) ? decl_q : defb_q;
	// empty window falls back to the declared budget, the deadline to the effective budget
	assign query_v  = (held_q == '0) ? decl_q : vq_ext[15:0];
	assign route_v  = (held_q == '0) ? decl_q : vr_ext[15:0];
	assign route_dl = (held_q == '0) ? 17'(budget) : 17'(vr_ext[15:0]);
	// bootstrapping until enough samples are held
	assign boot       = held_ext < CW'(need_q);
	assign fast_v     = boot ? declf_q : (route_v <= fastb_q);
	assign deadline_v = boot ? 17'(budget) + 17'(slack_q) : route_dl;

	// ---------------------------------------------------------------- sequencer
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	// result register takes a new result when empty or being emptied
	assign out_load      = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			held_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= s_axis_tuser ? ST_IDXQ : ST_REC;
					end
				end
				ST_REC: begin
					head_q  <= (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + AW'(1);
					held_q  <= held_new[NW-1:0];
					state_q <= ST_IDXQ;
				end
				ST_IDXQ: begin
					state_q <= (held_q == '0) ? ST_FIN : ST_IDXR;
				end
				ST_IDXR: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (eng_sts.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= s_axis_tuser;
			lat_q  <= s_axis_tdata[15:0];
			qf_q   <= s_axis_tdata[32:16];
		end
		if (state_q == ST_IDXQ) begin
			idxq_q <= idx_c;
		end
		if (out_load) begin
			oq_q    <= query_v;
			ofast_q <= fast_v;
			odl_q   <= deadline_v;
			ocnt_q  <= 7'(held_q);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, ocnt_q, odl_q, ofast_q, oq_q};

	// ---------------------------------------------------------------- checks
	// engine is never busy while a new transaction can be taken
	a_idle_engine: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !eng_sts.busy)
		else $error("selection engine busy while accepting a transaction");

	// engine finishes only while the sequencer waits for it
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		eng_sts.done |-> state_q == ST_SCAN)
		else $error("selection engine done outside of scan");

	// the ring head moves only on a recorded sample
	a_head_on_record: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(head_q) |-> $past(state_q) == ST_REC && !$past(mode_q))
		else $error("ring head moved without a record");

	// held count never exceeds the ring depth
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_ext <= CW'(WINDOW_DEPTH))
		else $error("held count above ring depth");

	// a finished result is never lost: the sequencer waits while the output is full
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && m_valid_q && !m_axis_tready |=> state_q == ST_FIN)
		else $error("result left the sequencer while output register was full");

endmodule

/* tb/sliding_latency_percentile_monitor_unit_test.sv */
// sliding_latency_percentile_monitor_unit_test: self-checking bench for the latency percentile monitor
// drives apb register writes and input stream transactions, predicts every result transaction
// depends on slpm_pkg and sliding_latency_percentile_monitor_unit
module sliding_latency_percentile_monitor_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_DEPTH = 64;
	localparam int LATENCY_BITS = 16;
	localparam int AW           = $clog2(WINDOW_DEPTH);

	// tuser codes of the input stream
	localparam logic MODE_RECORD = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	// latency mixes used by the random phases
	localparam int LAT_FULL_RANGE = 0;
	localparam int LAT_TIGHT      = 1;
	localparam int LAT_MID        = 2;

	// slowest item: one rank pass per latency bit over a full window
	localparam int DRAIN_CYCLES     = 1200;
	localparam int LONG_HOLD_CYCLES = 500;

	// result fields, highest bits first, as packed in m_axis_tdata[40:0]
	typedef struct packed {
		logic [6:0]  sample_count;
		logic [16:0] deadline_ms;
		logic        measured_fast;
		logic [15:0] query_latency_ms;
	} monitor_result_t;

	// shadow copy of the register file
	typedef struct {
		logic [6:0]  window_size;
		logic [16:0] route_fraction;
		logic [6:0]  samples_needed;
		logic [15:0] fast_below_ms;
		logic [15:0] declared_budget_ms;
		logic        declared_fast;
		logic [15:0] default_budget_ms;
		logic [15:0] boot_slack_ms;
	} monitor_regs_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [slpm_pkg::REG_ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0; // latency_ms[15:0], query_fraction[32:16]
	logic        s_axis_tuser = 1'b0; // mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [47:0] m_axis_tdata; // query_latency_ms[15:0], measured_fast[16],
	                           // deadline_ms[33:17], sample_count[40:34]

	// predictor state: ring of held samples, write pointer, number held
	logic [15:0]     sample_ring [WINDOW_DEPTH];
	logic [5:0]      write_ptr;
	logic [6:0]      samples_held;
	monitor_regs_t   regs;

	monitor_result_t pending_results [$];
	int              error_count = 0;
	bit              idle_enable = 1'b1;
	logic            hold_request = 1'b0;
	bit              hold_done = 1'b0;
	int              latency_style = LAT_FULL_RANGE;

	sliding_latency_percentile_monitor_unit #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.LATENCY_BITS (LATENCY_BITS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous limit: every item at a full window with the longest gaps and stalls,
	// taken five times over
	initial begin
		#80_000_000;
		$display("tb: failure");
		$finish;
	end

	// sorted-position lookup over the held samples, oldest to newest in the ring
	function automatic logic [15:0] window_percentile(input logic [16:0] fraction,
			input logic [15:0] fallback);
		logic [15:0] sorted [WINDOW_DEPTH];
		logic [15:0] v;
		longint      product;
		int          n;
		int          rank;
		int          i;
		int          j;
		n = samples_held;
		if (n == 0) begin
			return fallback;
		end
		for (i = 0; i < n; i++) begin
			sorted[AW'(i)] = sample_ring[AW'((int'(write_ptr) + WINDOW_DEPTH - (n - i))
				% WINDOW_DEPTH)];
		end
		for (i = 1; i < n; i++) begin
			v = sorted[AW'(i)];
			j = i - 1;
			while (j >= 0 && sorted[AW'(j)] > v) begin
				sorted[AW'(j + 1)] = sorted[AW'(j)];
				j--;
			end
			sorted[AW'(j + 1)] = v;
		end
		// rank is floor(n * q), clamped to the largest sample
		product = longint'(n) * longint'(fraction);
		rank = int'(product >> 16);
		if (rank >= n) begin
			rank = n - 1;
		end
		return sorted[AW'(rank)];
	endfunction

	// advances the shadow state by one input transaction and returns its result
	function automatic monitor_result_t predict_monitor_result(input logic mode,
			input logic [15:0] latency, input logic [16:0] fraction);
		monitor_result_t r;
		logic [15:0]     budget;
		logic [15:0]     route;
		int              keep;
		if (mode == MODE_RECORD) begin
			keep = (regs.window_size > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(regs.window_size);
			sample_ring[write_ptr] = latency;
			write_ptr++;
			if (samples_held < WINDOW_DEPTH) begin
				samples_held++;
			end
			// a shrunk window is only trimmed here, on the next recorded sample
			if (samples_held > keep) begin
				samples_held = keep[6:0];
			end
		end
		r.query_latency_ms = window_percentile(fraction, regs.declared_budget_ms);
		budget = (regs.declared_budget_ms != 0) ? regs.declared_budget_ms : regs.default_budget_ms;
		if (samples_held < regs.samples_needed) begin
			// still bootstrapping: trust the declaration
			r.measured_fast = regs.declared_fast;
			r.deadline_ms = {1'b0, budget} + {1'b0, regs.boot_slack_ms};
		end else begin
			route = window_percentile(regs.route_fraction, regs.declared_budget_ms);
			r.measured_fast = (route <= regs.fast_below_ms);
			r.deadline_ms = {1'b0, window_percentile(regs.route_fraction, budget)};
		end
		r.sample_count = samples_held;
		return r;
	endfunction

	function automatic logic [15:0] draw_latency();
		if ($urandom_range(0, 15) == 0) begin
			return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hffff;
		end
		case (latency_style)
			LAT_TIGHT: return 16'($urandom_range(0, 31));
			LAT_MID:   return 16'($urandom_range(0, 4095));
			default:   return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [16:0] draw_fraction();
		case ($urandom_range(0, 9))
			0:       return 17'd0;
			1:       return 17'd65536;
			2:       return 17'd65535;
			3:       return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic draw_mode();
		return ($urandom_range(0, 3) == 0) ? MODE_QUERY : MODE_RECORD;
	endfunction

	// one apb write: setup cycle, access cycle, then a spare cycle
	task automatic apb_write(input logic [2:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			slpm_pkg::REG_WINDOW_SIZE:     regs.window_size = value[6:0];
			slpm_pkg::REG_ROUTE_FRACTION:  regs.route_fraction = value[16:0];
			slpm_pkg::REG_SAMPLES_NEEDED:  regs.samples_needed = value[6:0];
			slpm_pkg::REG_FAST_BELOW:      regs.fast_below_ms = value[15:0];
			slpm_pkg::REG_DECLARED_BUDGET: regs.declared_budget_ms = value[15:0];
			slpm_pkg::REG_DECLARED_FAST:   regs.declared_fast = value[0];
			slpm_pkg::REG_DEFAULT_BUDGET:  regs.default_budget_ms = value[15:0];
			slpm_pkg::REG_BOOT_SLACK:      regs.boot_slack_ms = value[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// offers one input transaction, optionally after a short gap, and queues its prediction;
	// tvalid stays high on return so back-to-back items need no second assignment
	task automatic send_item(input logic mode, input logic [15:0] latency,
			input logic [16:0] fraction);
		monitor_result_t predicted;
		if (idle_enable && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, fraction, latency};
		s_axis_tuser <= mode;
		do @(posedge clk); while (!s_axis_tready);
		predicted = predict_monitor_result(mode, latency, fraction);
		pending_results = {pending_results, predicted};
	endtask

	// drop tvalid and wait until every queued result has been seen
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// empty window: query falls back to the declared budget
	task automatic test_empty_window();
		send_item(MODE_QUERY, 16'h0000, 17'd0);
		send_item(MODE_QUERY, 16'hffff, 17'd65536);
		wait_idle();
		apb_write(slpm_pkg::REG_DECLARED_BUDGET, 32'd500);
		apb_write(slpm_pkg::REG_DECLARED_FAST, 32'd1);
		send_item(MODE_QUERY, 16'h1234, 17'd32768);
	endtask

	// crosses the bootstrap threshold, with fractions at zero, one and above one
	task automatic test_bootstrap_crossing();
		wait_idle();
		apb_write(slpm_pkg::REG_SAMPLES_NEEDED, 32'd4);
		send_item(MODE_RECORD, 16'd0, 17'd0);
		send_item(MODE_RECORD, 16'hffff, 17'd65536);
		send_item(MODE_RECORD, 16'd700, 17'h1ffff);
		send_item(MODE_RECORD, 16'd700, 17'd32768);
		send_item(MODE_RECORD, 16'd1200, 17'd1);
		send_item(MODE_QUERY, 16'd0, 17'd65535);
	endtask

	// shrunk window: queries still see the old samples until the next record
	task automatic test_window_shrink();
		wait_idle();
		apb_write(slpm_pkg::REG_WINDOW_SIZE, 32'd2);
		send_item(MODE_QUERY, 16'd0, 17'd0);
		send_item(MODE_RECORD, 16'd300, 17'd65536);
		send_item(MODE_QUERY, 16'd0, 17'd0);
	endtask

	// zero window drops every sample; with no samples needed the fallbacks decide
	task automatic test_window_zero();
		wait_idle();
		apb_write(slpm_pkg::REG_WINDOW_SIZE, 32'd0);
		apb_write(slpm_pkg::REG_SAMPLES_NEEDED, 32'd0);
		apb_write(slpm_pkg::REG_DECLARED_BUDGET, 32'd0);
		send_item(MODE_RECORD, 16'd999, 17'd32768);
		send_item(MODE_QUERY, 16'd0, 17'd65536);
		wait_idle();
		apb_write(slpm_pkg::REG_DECLARED_BUDGET, 32'd1234);
		send_item(MODE_QUERY, 16'd0, 17'd0);
	endtask

	// largest bootstrap deadline, then routing percentile at both ends
	task automatic test_budget_extremes();
		wait_idle();
		apb_write(slpm_pkg::REG_WINDOW_SIZE, 32'd64);
		apb_write(slpm_pkg::REG_SAMPLES_NEEDED, 32'd64);
		apb_write(slpm_pkg::REG_DECLARED_BUDGET, 32'd65535);
		apb_write(slpm_pkg::REG_BOOT_SLACK, 32'd65535);
		send_item(MODE_RECORD, 16'd40000, 17'd0);
		wait_idle();
		apb_write(slpm_pkg::REG_DECLARED_BUDGET, 32'd0);
		apb_write(slpm_pkg::REG_DEFAULT_BUDGET, 32'd65535);
		apb_write(slpm_pkg::REG_DECLARED_FAST, 32'd0);
		send_item(MODE_RECORD, 16'd100, 17'd16384);
		wait_idle();
		apb_write(slpm_pkg::REG_SAMPLES_NEEDED, 32'd1);
		apb_write(slpm_pkg::REG_ROUTE_FRACTION, 32'd0);
		apb_write(slpm_pkg::REG_FAST_BELOW, 32'd0);
		send_item(MODE_RECORD, 16'd0, 17'd65536);
		wait_idle();
		apb_write(slpm_pkg::REG_ROUTE_FRACTION, 32'd65536);
		apb_write(slpm_pkg::REG_FAST_BELOW, 32'd65535);
		send_item(MODE_QUERY, 16'd0, 17'd49152);
	endtask

	// each phase loads a fresh register set while idle, then streams random items;
	// windows are mostly small to keep the rank passes short, a few go to the full depth
	task automatic test_random_phases(input int phase_count, input int items_per_phase);
		monitor_regs_t c;
		int            p;
		int            k;
		int            cap;
		for (p = 0; p < phase_count; p++) begin
			wait_idle();
			latency_style = $urandom_range(LAT_FULL_RANGE, LAT_MID);
			case ($urandom_range(0, 9))
				0:       c.window_size = 7'd0;
				1:       c.window_size = 7'd64;
				2, 3:    c.window_size = 7'($urandom_range(13, 32));
				default: c.window_size = 7'($urandom_range(1, 12));
			endcase
			cap = (int'(c.window_size) + 2 > 64) ? 64 : int'(c.window_size) + 2;
			case ($urandom_range(0, 5))
				0:       c.samples_needed = 7'd0;
				1:       c.samples_needed = 7'd64;
				2:       c.samples_needed = 7'd1;
				default: c.samples_needed = 7'($urandom_range(0, cap));
			endcase
			case ($urandom_range(0, 5))
				0:       c.route_fraction = 17'd0;
				1:       c.route_fraction = 17'd65536;
				2:       c.route_fraction = 17'd32768;
				default: c.route_fraction = 17'($urandom_range(0, 65536));
			endcase
			case ($urandom_range(0, 5))
				0:       c.fast_below_ms = 16'd0;
				1:       c.fast_below_ms = 16'hffff;
				default: c.fast_below_ms = draw_latency(); // near the samples, both classes show
			endcase
			c.declared_budget_ms = ($urandom_range(0, 1) == 0) ? 16'd0
				: 16'($urandom_range(1, 65535));
			c.declared_fast = 1'($urandom_range(0, 1));
			c.default_budget_ms = ($urandom_range(0, 4) == 0) ? 16'hffff
				: 16'($urandom_range(0, 65535));
			c.boot_slack_ms = ($urandom_range(0, 4) == 0) ? 16'hffff
				: 16'($urandom_range(0, 65535));
			apb_write(slpm_pkg::REG_WINDOW_SIZE, 32'(c.window_size));
			apb_write(slpm_pkg::REG_ROUTE_FRACTION, 32'(c.route_fraction));
			apb_write(slpm_pkg::REG_SAMPLES_NEEDED, 32'(c.samples_needed));
			apb_write(slpm_pkg::REG_FAST_BELOW, 32'(c.fast_below_ms));
			apb_write(slpm_pkg::REG_DECLARED_BUDGET, 32'(c.declared_budget_ms));
			apb_write(slpm_pkg::REG_DECLARED_FAST, 32'(c.declared_fast));
			apb_write(slpm_pkg::REG_DEFAULT_BUDGET, 32'(c.default_budget_ms));
			apb_write(slpm_pkg::REG_BOOT_SLACK, 32'(c.boot_slack_ms));
			for (k = 0; k < items_per_phase; k++) begin
				send_item(draw_mode(), draw_latency(), draw_fraction());
			end
		end
	endtask

	// result side stalls for a long stretch while items keep coming, so the block
	// fills its result slot and pushes back on the input
	task automatic test_backpressure();
		wait_idle();
		apb_write(slpm_pkg::REG_WINDOW_SIZE, 32'd3);
		apb_write(slpm_pkg::REG_SAMPLES_NEEDED, 32'd2);
		hold_request <= 1'b1;
		repeat (24) send_item(draw_mode(), draw_latency(), draw_fraction());
	endtask

	// result receiver: random short stalls, or one long hold when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else if (idle_enable && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	// every result transaction is matched against the oldest prediction
	always @(posedge clk) begin : result_check
		monitor_result_t got;
		monitor_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = monitor_result_t'(m_axis_tdata[40:0]);
			if (pending_results.size() == 0) begin
				$error("result transaction with none expected: %h", m_axis_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.query_latency_ms !== want.query_latency_ms) begin
					$error("query_latency_ms: expected %0d, actual %0d",
						want.query_latency_ms, got.query_latency_ms);
					error_count++;
				end
				if (got.measured_fast !== want.measured_fast) begin
					$error("measured_fast: expected %0d, actual %0d",
						want.measured_fast, got.measured_fast);
					error_count++;
				end
				if (got.deadline_ms !== want.deadline_ms) begin
					$error("deadline_ms: expected %0d, actual %0d",
						want.deadline_ms, got.deadline_ms);
					error_count++;
				end
				if (got.sample_count !== want.sample_count) begin
					$error("sample_count: expected %0d, actual %0d",
						want.sample_count, got.sample_count);
					error_count++;
				end
			end
		end
	end

	initial begin
		// shadow state matches the block after reset; unwritten ring entries are never read
		foreach (sample_ring[i]) sample_ring[i] = '0;
		write_ptr = '0;
		samples_held = '0;
		regs.window_size = slpm_pkg::RST_WINDOW_SIZE;
		regs.route_fraction = slpm_pkg::RST_ROUTE_FRACTION;
		regs.samples_needed = slpm_pkg::RST_SAMPLES_NEEDED;
		regs.fast_below_ms = slpm_pkg::RST_FAST_BELOW;
		regs.declared_budget_ms = slpm_pkg::RST_DECLARED_BUDGET;
		regs.declared_fast = slpm_pkg::RST_DECLARED_FAST;
		regs.default_budget_ms = slpm_pkg::RST_DEFAULT_BUDGET;
		regs.boot_slack_ms = slpm_pkg::RST_BOOT_SLACK;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_window();
		test_bootstrap_crossing();
		test_window_shrink();
		test_window_zero();
		test_budget_extremes();
		test_random_phases(30, 40);
		test_backpressure();

		// closing stretch with both sides running flat out
		wait_idle();
		idle_enable = 1'b0;
		test_random_phases(5, 40);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/slpm_pkg.sv
hdl/slpm_select.sv
hdl/sliding_latency_percentile_monitor_unit.sv
tb/sliding_latency_percentile_monitor_unit_test.sv
